// ----- hw/rtl/cbs_pkg.sv -----
`timescale 1ns / 1ps

package cbs_pkg;

   localparam int VOLT_W         = 16;
   localparam int NUM_W          = 4;
   localparam int MASK_W         = 12;
   localparam int OUT_IDX_W      = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int MAX_CELLS_DEF  = 12;

   // 5.0 V in 100 uV units
   localparam logic [VOLT_W-1:0] EXCESS_DEFAULT = 16'd50000;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FLOOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CELLS = 2'd2;

   localparam logic [NUM_W-1:0] NUM_CELLS_RESET = 4'd12;

   typedef struct packed {
      logic load;
      logic eval;
      logic shift;
   } cbs_ctrl_type;

endpackage

// ----- hw/rtl/cell_balance_selector_core.sv -----
`timescale 1ns / 1ps

// Cell balance selector. Feed one raw cell voltage (100 uV units) per transfer, in cell
// order; a set holds num_cells cells (zero reads as one, values above MAX_CELLS read as
// MAX_CELLS). Voltages load at one per cycle into a row of cells, one cell per stored
// voltage, while the running minimum is kept. The transfer that closes the set starts a
// judging step in which every cell compares itself against minimum plus delta at once,
// then the row shifts its results toward cell zero, one result per cycle as rsp_ready
// allows; no new voltage is taken until the last result of the set is transferred. No
// clearing pass is needed after reset. Configuration writes are always ready and take
// effect at once.
module cell_balance_selector_core import cbs_pkg::*; #(
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VOLT_W-1:0]     req_cell_voltage,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_IDX_W-1:0]  rsp_cell_index,
   output logic                  rsp_balance_flag,
   output logic [VOLT_W-1:0]     rsp_voltage_excess,
   output logic [VOLT_W-1:0]     rsp_minimum_voltage,
   output logic [MASK_W-1:0]     rsp_balance_mask,
   output logic                  rsp_last_result,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VOLT_W-1:0]     csr_data
);

   localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CNT_W = $clog2(MAX_CELLS + 1);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_EVAL = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [VOLT_W-1:0] floor_ff;
   logic [VOLT_W-1:0] delta_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [VOLT_W-1:0] min_ff, min_in;
   logic [IDX_W-1:0]  loaded_ff, loaded_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [MASK_W-1:0] mask_ff, mask_in;

   logic [4:0]        n_wide;
   logic [CNT_W-1:0]  n_eff;
   logic [CNT_W:0]    slot_plus;
   logic              req_xfer, rsp_xfer, set_close, out_last;
   logic [VOLT_W:0]   limit;
   logic              allowed;
   cbs_ctrl_type      ctrl;

   logic                flag_next [MAX_CELLS];
   logic                flag_q    [MAX_CELLS+1];
   logic [VOLT_W-1:0]   excess_q  [MAX_CELLS+1];

   always_comb begin
      n_wide = (num_ff == '0) ? 5'd1 : {1'b0, num_ff};
      if (n_wide > 5'(MAX_CELLS)) begin
         n_wide = 5'(MAX_CELLS);
      end
   end
   assign n_eff = n_wide[CNT_W-1:0];

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   assign slot_plus = (CNT_W+1)'(loaded_ff) + (CNT_W+1)'(1);
   assign set_close = slot_plus >= {1'b0, n_eff};
   assign out_last  = ((CNT_W+1)'(out_idx_ff) + (CNT_W+1)'(1)) == {1'b0, n_eff};

   assign limit   = {1'b0, min_ff} + {1'b0, delta_ff};
   assign allowed = min_ff > floor_ff;

   // load, eval, shift
   assign ctrl = {req_xfer, (state_ff == ST_EVAL), rsp_xfer};

   always_comb begin
      state_in   = state_ff;
      min_in     = min_ff;
      loaded_in  = loaded_ff;
      out_idx_in = out_idx_ff;
      mask_in    = mask_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (loaded_ff == '0 || req_cell_voltage < min_ff) begin
                  min_in = req_cell_voltage;
               end
               if (set_close) begin
                  loaded_in = '0;
                  state_in  = ST_EVAL;
               end else begin
                  loaded_in = slot_plus[IDX_W-1:0];
               end
            end
         end
         ST_EVAL: begin
            mask_in = '0;
            for (int i = 0; i < MASK_W; i++) begin
               if (i < MAX_CELLS) begin
                  mask_in[i] = flag_next[i];
               end
            end
            out_idx_in = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (out_last) begin
                  state_in = ST_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         floor_ff   <= '0;
         delta_ff   <= '0;
         num_ff     <= NUM_CELLS_RESET;
         min_ff     <= '0;
         loaded_ff  <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         min_ff     <= min_in;
         loaded_ff  <= loaded_in;
         out_idx_ff <= out_idx_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN_FLOOR: floor_ff <= csr_data;
               CSR_DELTA:     delta_ff <= csr_data;
               CSR_NUM_CELLS: num_ff   <= csr_data[NUM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end

   assign flag_q[MAX_CELLS]   = 1'b0;
   assign excess_q[MAX_CELLS] = EXCESS_DEFAULT;

   for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
      cbs_cell #(
         .INDEX (g),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .slot      (loaded_ff),
         .count     (n_eff),
         .voltage   (req_cell_voltage),
         .minimum   (min_ff),
         .limit     (limit),
         .allowed   (allowed),
         .nb_flag   (flag_q[g+1]),
         .nb_excess (excess_q[g+1]),
         .flag_next (flag_next[g]),
         .flag      (flag_q[g]),
         .excess    (excess_q[g])
      );
   end

   assign rsp_cell_index      = OUT_IDX_W'(out_idx_ff);
   assign rsp_balance_flag    = flag_q[0];
   assign rsp_voltage_excess  = excess_q[0];
   assign rsp_minimum_voltage = min_ff;
   assign rsp_balance_mask    = mask_ff;
   assign rsp_last_result     = out_last;

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_last_result |=> req_ready)
      else $error("input not reopened after last result");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("load and result phases overlap");

   a_close_judges: assert property (@(posedge clock) disable iff (reset)
      req_xfer && set_close |=> ctrl.eval && !rsp_valid)
      else $error("closed set not judged");

   a_flag_excess: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_balance_flag |-> rsp_voltage_excess > delta_ff)
      else $error("flagged cell excess not above delta");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CNT_W'(out_idx_ff) < n_eff))
      else $error("result index beyond set");

endmodule

// ----- hw/rtl/cbs_cell.sv -----
`timescale 1ns / 1ps

module cbs_cell import cbs_pkg::*; #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4,
   parameter int CNT_W = 4
) (
   input  logic                clock,
   input  cbs_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]    slot,
   input  logic [CNT_W-1:0]    count,
   input  logic [VOLT_W-1:0]   voltage,
   input  logic [VOLT_W-1:0]   minimum,
   input  logic [VOLT_W:0]     limit,
   input  logic                allowed,
   input  logic                nb_flag,
   input  logic [VOLT_W-1:0]   nb_excess,
   output logic                flag_next,
   output logic                flag,
   output logic [VOLT_W-1:0]   excess
);

   logic [VOLT_W-1:0] volt_ff;
   logic              flag_ff;
   logic [VOLT_W-1:0] excess_ff;

   assign flag_next = allowed && (CNT_W'(INDEX) < count) && ({1'b0, volt_ff} > limit);
   assign flag      = flag_ff;
   assign excess    = excess_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load && slot == IDX_W'(INDEX)) begin
         volt_ff <= voltage;
      end
      if (ctrl.eval) begin
         flag_ff   <= flag_next;
         excess_ff <= flag_next ? (volt_ff - minimum) : EXCESS_DEFAULT;
      end else if (ctrl.shift) begin
         // advance toward cell zero
         flag_ff   <= nb_flag;
         excess_ff <= nb_excess;
      end
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import cbs_pkg::*;

   localparam int          TOTAL_CELLS  = 430;
   localparam int          QUIET_FROM   = 360;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] idx;
      logic                 flag;
      logic [VOLT_W-1:0]    excess;
      logic [VOLT_W-1:0]    minv;
      logic [MASK_W-1:0]    mask;
      logic                 last;
   } cell_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [VOLT_W-1:0]    req_cell_voltage = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_IDX_W-1:0] rsp_cell_index;
   logic                 rsp_balance_flag;
   logic [VOLT_W-1:0]    rsp_voltage_excess;
   logic [VOLT_W-1:0]    rsp_minimum_voltage;
   logic [MASK_W-1:0]    rsp_balance_mask;
   logic                 rsp_last_result;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VOLT_W-1:0]    csr_data = '0;

   cell_balance_selector_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cell_voltage    (req_cell_voltage),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_index      (rsp_cell_index),
      .rsp_balance_flag    (rsp_balance_flag),
      .rsp_voltage_excess  (rsp_voltage_excess),
      .rsp_minimum_voltage (rsp_minimum_voltage),
      .rsp_balance_mask    (rsp_balance_mask),
      .rsp_last_result     (rsp_last_result),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // predictor state
   logic [VOLT_W-1:0] volt_store [MAX_CELLS_DEF];
   logic [VOLT_W-1:0] low_volt = '0;
   int unsigned       cells_held = 0;
   logic [VOLT_W-1:0] cfg_floor = '0;
   logic [VOLT_W-1:0] cfg_delta = '0;
   logic [NUM_W-1:0]  cfg_cells = NUM_CELLS_RESET;

   logic [VOLT_W-1:0] volt_queue [$];
   cell_result_type   pending_results [$];
   int unsigned       cells_queued = 0;
   int unsigned       cells_taken = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   bit                req_acc = 1'b0;
   bit                quiet = 1'b0;
   int                req_gap = 0;
   int                rsp_gap = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Store one cell; on the cell that closes the set, queue one result per counted cell.
   task automatic predict_cell(input logic [VOLT_W-1:0] v);
      int unsigned             n;
      int unsigned             slot;
      logic [VOLT_W:0]         limit;
      logic [MAX_CELLS_DEF-1:0] flags;
      cell_result_type         r;
      n = (cfg_cells == 0) ? 1 :
          ((cfg_cells > MAX_CELLS_DEF) ? MAX_CELLS_DEF : cfg_cells);
      slot = (cells_held >= MAX_CELLS_DEF) ? MAX_CELLS_DEF - 1 : cells_held;
      volt_store[slot] = v;
      if (slot == 0 || v < low_volt) low_volt = v;
      if (slot + 1 < n) begin
         cells_held = slot + 1;
         return;
      end
      cells_held = 0;
      flags = '0;
      limit = {1'b0, low_volt} + {1'b0, cfg_delta};
      for (int i = 0; i < n; i++)
         flags[i] = (low_volt > cfg_floor) && ({1'b0, volt_store[i]} > limit);
      for (int i = 0; i < n; i++) begin
         r.idx    = OUT_IDX_W'(i);
         r.flag   = flags[i];
         r.excess = flags[i] ? volt_store[i] - low_volt : EXCESS_DEFAULT;
         r.minv   = low_volt;
         r.mask   = flags[MASK_W-1:0];
         r.last   = (i + 1 == n);
         pending_results.push_back(r);
      end
   endtask

   // monitor: sample at the rising edge, update the predictor, check results
   always @(posedge clock) begin : monitor
      cell_result_type want;
      cell_result_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      req_acc = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_FLOOR: cfg_floor = csr_data;
               CSR_DELTA:     cfg_delta = csr_data;
               CSR_NUM_CELLS: cfg_cells = csr_data[NUM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            req_acc = 1'b1;
            cells_taken++;
            predict_cell(req_cell_voltage);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cell_index, rsp_balance_flag, rsp_voltage_excess,
                   rsp_minimum_voltage, rsp_balance_mask, rsp_last_result};
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"unexpected result: idx=%0d flag=%0d excess=%0d",
                            " min=%0d mask=%03h last=%0d"},
                           got.idx, got.flag, got.excess, got.minv, got.mask, got.last);
            end else begin
               want = pending_results.pop_front();
               if (got.idx !== want.idx || got.flag !== want.flag ||
                   got.excess !== want.excess || got.minv !== want.minv ||
                   got.mask !== want.mask || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display({"mismatch: exp idx=%0d flag=%0d excess=%0d",
                               " min=%0d mask=%03h last=%0d"},
                              want.idx, want.flag, want.excess, want.minv,
                              want.mask, want.last);
                     $display({"          got idx=%0d flag=%0d excess=%0d",
                               " min=%0d mask=%03h last=%0d"},
                              got.idx, got.flag, got.excess, got.minv,
                              got.mask, got.last);
                  end
               end
            end
         end
      end
   end

   // cell driver: hold a pending transfer, otherwise idle in bursts or present the next cell
   always @(negedge clock) begin : cell_driver
      logic              nv;
      logic [VOLT_W-1:0] nd;
      nv = req_valid;
      nd = req_cell_voltage;
      if (reset) begin
         nv = 1'b0;
      end else if (!(req_valid && !req_acc)) begin
         if (req_gap > 0) begin
            req_gap--;
            nv = 1'b0;
         end else if (volt_queue.size() > 0) begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
               req_gap = $urandom_range(1, 6) - 1;
               nv = 1'b0;
            end else begin
               nd = volt_queue.pop_front();
               nv = 1'b1;
            end
         end else begin
            nv = 1'b0;
         end
      end
      req_valid <= nv;
      req_cell_voltage <= nd;
   end

   // result side stalls
   always @(negedge clock) begin : result_sink
      logic rdy;
      if (reset) begin
         rdy = 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(1, 6) - 1;
         rdy = 1'b0;
      end else begin
         rdy = 1'b1;
      end
      rsp_ready <= rdy;
   end

   task automatic send_cell(input logic [VOLT_W-1:0] v);
      volt_queue.push_back(v);
      cells_queued++;
   endtask

   // Hold until every cell is taken and every result is out, then let the block settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (cells_taken != cells_queued || pending_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [VOLT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // only the low nibble counts; fill the rest with noise
   task automatic set_cell_count(input int unsigned n);
      logic [VOLT_W-NUM_W-1:0] junk;
      junk = (VOLT_W-NUM_W)'($urandom);
      csr_write(CSR_NUM_CELLS, {junk, NUM_W'(n)});
   endtask

   initial begin : stimulus
      int unsigned       floor_now;
      int unsigned       delta_now;
      int unsigned       cnt_raw;
      int unsigned       set_len;
      int unsigned       sets;
      int unsigned       style;
      int unsigned       base;
      int unsigned       spread;
      int unsigned       v;
      int unsigned       part;
      logic [VOLT_W-1:0] first_set [12];

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: a zero cell keeps the minimum at the floor, so nothing is balanced
      first_set = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd1, 16'd2,
                    16'h8000, 16'h7FFF, 16'd100, 16'hFFFE, 16'd3000, 16'd40000};
      foreach (first_set[i]) send_cell(first_set[i]);
      wait_drained();

      // floor passed, two cells above the minimum
      csr_write(CSR_MIN_FLOOR, 16'd100);
      csr_write(CSR_DELTA, 16'd0);
      set_cell_count(3);
      send_cell(16'hFFFF);
      send_cell(16'd200);
      send_cell(16'd201);
      wait_drained();

      // minimum plus delta needs the 17th bit
      csr_write(CSR_MIN_FLOOR, 16'd0);
      csr_write(CSR_DELTA, 16'hFFFF);
      set_cell_count(2);
      send_cell(16'hFFFF);
      send_cell(16'd1);
      wait_drained();

      // zero count reads as one
      set_cell_count(0);
      send_cell(16'd40000);
      wait_drained();

      // lower the count below the cells already loaded
      set_cell_count(4);
      send_cell(16'd10);
      send_cell(16'd20);
      send_cell(16'd30);
      wait_drained();
      csr_write(CSR_DELTA, 16'd5);
      set_cell_count(2);
      send_cell(16'd40);
      wait_drained();
      csr_write(CSR_UNUSED, 16'hFFFF);

      floor_now = 0;
      delta_now = 5;
      cnt_raw = 2;
      while (cells_queued < TOTAL_CELLS) begin
         if (cells_queued >= QUIET_FROM) quiet = 1'b1;
         case ($urandom_range(0, 7))
            0: begin floor_now = 0;     delta_now = 0; end
            1: begin floor_now = 65535; delta_now = $urandom_range(0, 200); end
            2: begin floor_now = $urandom_range(0, 30000); delta_now = 65535; end
            3: begin
               floor_now = $urandom_range(0, 65535);
               delta_now = $urandom_range(0, 65535);
            end
            default: begin
               floor_now = $urandom_range(0, 30000);
               delta_now = $urandom_range(0, 400);
            end
         endcase
         if ($urandom_range(0, 3) != 0) csr_write(CSR_MIN_FLOOR, VOLT_W'(floor_now));
         if ($urandom_range(0, 3) != 0) csr_write(CSR_DELTA, VOLT_W'(delta_now));
         if ($urandom_range(0, 3) != 0) begin
            cnt_raw = ($urandom_range(0, 2) == 0) ? 12 : $urandom_range(0, 15);
            set_cell_count(cnt_raw);
         end
         if ($urandom_range(0, 7) == 0) csr_write(CSR_UNUSED, VOLT_W'($urandom));
         set_len = (cnt_raw == 0) ? 1 : ((cnt_raw > 12) ? 12 : cnt_raw);
         sets = $urandom_range(2, 5);
         for (int s = 0; s < sets; s++) begin
            style = $urandom_range(0, 3);
            base = $urandom_range(0, 65535);
            if (style == 1 && floor_now < 65535) base = $urandom_range(floor_now + 1, 65535);
            spread = (1 << $urandom_range(2, 16)) - 1;
            // a broken set now and then, left open for the next settings
            part = (s + 1 == sets && set_len > 1 && $urandom_range(0, 3) == 0) ?
                   $urandom_range(1, set_len - 1) : set_len;
            for (int c = 0; c < part; c++) begin
               case (style)
                  0: v = $urandom_range(0, 65535);
                  2: begin
                     case ($urandom_range(0, 2))
                        0: v = 0;
                        1: v = 65535;
                        default: v = base;
                     endcase
                  end
                  default: v = base + $urandom_range(0, spread);
               endcase
               if (v > 65535) v = 65535;
               send_cell(VOLT_W'(v));
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (30) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/cbs_pkg.sv
hw/rtl/cbs_cell.sv
hw/rtl/cell_balance_selector_core.sv
tb/tb_top.sv
